[design/civ_frame_transceiver_unit_defines.svh]
// Assertion helpers shared by the checker.
`ifndef CIV_FRAME_TRANSCEIVER_UNIT_DEFINES_SVH
`define CIV_FRAME_TRANSCEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define CFT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cft_pkg.sv]
`timescale 1ns / 1ps
package cft_pkg;

  localparam int FRAME_DEPTH = 13;
  localparam int POS_W       = $clog2(FRAME_DEPTH + 4);
  localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);
  localparam int IDX_W       = $clog2(FRAME_DEPTH);

  localparam int RES_DEPTH   = 4;
  localparam int RES_PTR_W   = $clog2(RES_DEPTH);
  localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

  localparam logic [7:0] PRE_BYTE = 8'hFE;
  localparam logic [7:0] END_BYTE = 8'hFD;

  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_START   = 2'd1;
  localparam logic [1:0] REQ_BUS     = 2'd2;
  localparam logic [1:0] REQ_TIMEOUT = 2'd3;

  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_BODY = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_RESP  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [1:0] CFG_TARGET = 2'd0;
  localparam logic [1:0] CFG_CTRL   = 2'd1;
  localparam logic [1:0] CFG_RETRY  = 2'd2;

  localparam logic [7:0] TARGET_RST = 8'h00;
  localparam logic [7:0] CTRL_RST   = 8'hE0;
  localparam logic [3:0] RETRY_RST  = 4'd4;

  typedef enum logic [6:0] {
    PH_IDLE       = 7'b0000001,
    PH_ECHO       = 7'b0000010,
    PH_DISCARD    = 7'b0000100,
    PH_HUNT       = 7'b0001000,
    PH_SKIP_PRE   = 7'b0010000,
    PH_CHK_TARGET = 7'b0100000,
    PH_RX_BODY    = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] slot;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic [3:0] resp_count;
    logic       last;
  } res_item_t;

  // Results produced by one item: push_cnt is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] push_cnt;
    res_item_t  r0;
    res_item_t  r1;
  } push_t;

  typedef struct packed {
    logic       en;
    logic [1:0] index;
    logic [7:0] data;
  } cfg_wr_t;

endpackage

[design/civ_frame_transceiver_unit.sv]
`timescale 1ns / 1ps
// Half-duplex frame engine for an echoing radio control bus.
// Input channel (in_valid_i/in_ready_o, in_data_i): load a command byte into
// a slot, start a frame, hand over a byte seen on the bus, or report a
// receive timeout. Output channel (out_valid_o/out_ready_i, out_data_o):
// bytes to transmit, response body bytes and one end result per transaction
// carrying the status and the response byte count.
// Configuration channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i):
// target address, controller address and retry limit; always ready, and to
// be written only while no transaction is running.
// An accepted item is held in an input register, processed from there once
// the result queue has room, and its results are queued in a four-entry
// result queue; the first result is registered into the queue head.
// One item is taken per cycle while the result queue has room.
// An item may give two results (last body byte and overflow end), so the
// input register holds its item while the queue has fewer than two free
// entries; a stalled receiver thus backs up into in_ready_o without loss.
// Reset clears the queue, the state machine and the configuration registers
// to their defaults; the command store holds nothing until it is loaded.
module civ_frame_transceiver_unit import cft_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output res_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  in_item_t in_q;
  logic     in_vld_q;
  logic     room;
  logic     take;
  push_t    push;
  cfg_wr_t  cfg_wr;

  assign take        = in_vld_q && room;
  assign in_ready_o  = !in_vld_q || take;
  assign cfg_ready_o = 1'b1;

  assign cfg_wr.en    = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_data_i;
  end

  cft_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_wr),
    .item_valid_i (take),
    .item_i       (in_q),
    .push_o       (push)
  );

  cft_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_valid_o && out_ready_i),
    .valid_o (out_valid_o),
    .data_o  (out_data_o),
    .room_o  (room)
  );

endmodule

[design/cft_core.sv]
`timescale 1ns / 1ps
module cft_core import cft_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_wr_t  cfg_i,
  input  logic     item_valid_i,
  input  in_item_t item_i,
  output push_t    push_o
);

  logic [7:0]       target_q, ctrl_q;
  logic [3:0]       retry_q;
  logic [7:0]       store_q [FRAME_DEPTH];
  logic [7:0]       cmd0_q;
  phase_e           phase_q, phase_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       echo_q, echo_d;
  logic [3:0]       att_q, att_d;
  logic [CNT_W-1:0] body_q, body_d;

  logic             store_we;
  logic [7:0]       rx;
  logic [POS_W-1:0] rd_off;
  logic [POS_W-1:0] rd_nxt;
  logic [7:0]       store_rd_q;
  logic [CNT_W-1:0] body_inc;
  logic             do_begin;

  function automatic res_item_t mk_tx(input logic [7:0] b);
    res_item_t r;
    r = '0;
    r.out_kind = KIND_TX;
    r.out_byte = b;
    return r;
  endfunction

  function automatic res_item_t mk_end(input logic [1:0] st, input logic [3:0] cnt);
    res_item_t r;
    r = '0;
    r.out_kind   = KIND_END;
    r.status     = st;
    r.resp_count = cnt;
    r.last       = 1'b1;
    return r;
  endfunction

  assign rx       = (item_i.req_type == REQ_TIMEOUT) ? END_BYTE : item_i.data_byte;
  assign rd_off   = pos_q - POS_W'(3);
  assign rd_nxt   = pos_d - POS_W'(3);
  assign body_inc = body_q + CNT_W'(1);
  assign store_we = item_valid_i && (item_i.req_type == REQ_LOAD) && (phase_q == PH_IDLE)
                    && (32'(item_i.slot) < FRAME_DEPTH);

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    echo_d   = echo_q;
    att_d    = att_q;
    body_d   = body_q;
    push_o   = '0;
    do_begin = 1'b0;

    if (item_valid_i) begin
      if (item_i.req_type == REQ_START) begin
        if (phase_q == PH_IDLE) begin
          att_d    = '0;
          do_begin = 1'b1;
        end
      end else if (item_i.req_type != REQ_LOAD) begin
        case (phase_q)
          PH_IDLE: begin
          end
          PH_ECHO: begin
            if (rx != echo_q) begin
              phase_d = PH_DISCARD;
            end else if (pos_q == POS_W'(0)) begin
              pos_d = POS_W'(1);
              echo_d = PRE_BYTE;
              push_o.push_cnt = 2'd1;
              push_o.r0 = mk_tx(PRE_BYTE);
            end else if (pos_q == POS_W'(1)) begin
              pos_d = POS_W'(2);
              echo_d = target_q;
              push_o.push_cnt = 2'd1;
              push_o.r0 = mk_tx(target_q);
            end else if (pos_q == POS_W'(2)) begin
              pos_d = POS_W'(3);
              echo_d = ctrl_q;
              push_o.push_cnt = 2'd1;
              push_o.r0 = mk_tx(ctrl_q);
            end else if (pos_q == POS_W'(3)) begin
              pos_d = POS_W'(4);
              echo_d = cmd0_q;
              push_o.push_cnt = 2'd1;
              push_o.r0 = mk_tx(cmd0_q);
            end else if ((echo_q != END_BYTE) && (32'(rd_off) < FRAME_DEPTH)) begin
              pos_d = pos_q + POS_W'(1);
              echo_d = store_rd_q;
              push_o.push_cnt = 2'd1;
              push_o.r0 = mk_tx(store_rd_q);
            end else if (cmd0_q <= 8'd1) begin
              // Commands that expect no reply end as soon as the frame is out.
              phase_d = PH_IDLE;
              push_o.push_cnt = 2'd1;
              push_o.r0 = mk_end(ST_OK, 4'd0);
            end else begin
              phase_d = PH_HUNT;
            end
          end
          PH_DISCARD: begin
            if (rx == END_BYTE) begin
              if (att_q != 4'd15) att_d = att_q + 4'd1;
              do_begin = 1'b1;
            end
          end
          PH_HUNT: begin
            if ((rx == END_BYTE) || (rx == PRE_BYTE)) phase_d = PH_SKIP_PRE;
          end
          PH_SKIP_PRE: begin
            if (rx != PRE_BYTE) begin
              if (rx != ctrl_q) begin
                if (att_q != 4'd15) att_d = att_q + 4'd1;
                do_begin = 1'b1;
              end else begin
                phase_d = PH_CHK_TARGET;
              end
            end
          end
          PH_CHK_TARGET: begin
            if (rx != target_q) begin
              if (att_q != 4'd15) att_d = att_q + 4'd1;
              do_begin = 1'b1;
            end else begin
              phase_d = PH_RX_BODY;
              body_d  = '0;
            end
          end
          PH_RX_BODY: begin
            if (rx == END_BYTE) begin
              phase_d = PH_IDLE;
              push_o.push_cnt = 2'd1;
              push_o.r0 = mk_end(ST_OK, 4'(body_q));
            end else begin
              body_d = body_inc;
              push_o.push_cnt = 2'd1;
              push_o.r0 = '0;
              push_o.r0.out_kind = KIND_BODY;
              push_o.r0.out_byte = rx;
              if (32'(body_inc) >= FRAME_DEPTH) begin
                phase_d = PH_IDLE;
                push_o.push_cnt = 2'd2;
                push_o.r1 = mk_end(ST_OVERFLOW, 4'(body_inc));
              end
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end

    // Start of a frame attempt, or giving up once the attempts are spent.
    if (do_begin) begin
      push_o.push_cnt = 2'd1;
      if (att_d >= retry_q) begin
        phase_d = PH_IDLE;
        push_o.r0 = mk_end(ST_NO_RESP, 4'd0);
      end else begin
        phase_d = PH_ECHO;
        pos_d = '0;
        echo_d = PRE_BYTE;
        push_o.r0 = mk_tx(PRE_BYTE);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      echo_q  <= '0;
      att_q   <= '0;
      body_q  <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      echo_q  <= echo_d;
      att_q   <= att_d;
      body_q  <= body_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RST;
      ctrl_q   <= CTRL_RST;
      retry_q  <= RETRY_RST;
    end else if (cfg_i.en) begin
      case (cfg_i.index)
        CFG_TARGET: target_q <= cfg_i.data;
        CFG_CTRL:   ctrl_q   <= cfg_i.data;
        CFG_RETRY:  retry_q  <= cfg_i.data[3:0];
        default: begin
        end
      endcase
    end
  end

  // The first command byte is kept apart so the store needs one read port only.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[IDX_W'(item_i.slot)] <= item_i.data_byte;
      if (item_i.slot == 4'd0) cmd0_q <= item_i.data_byte;
    end
    // The byte for the position about to be held is read ahead, so it is ready
    // when that position's echo comes back.
    if (32'(rd_nxt) < FRAME_DEPTH) store_rd_q <= store_q[IDX_W'(rd_nxt)];
  end

endmodule

[design/cft_res_fifo.sv]
`timescale 1ns / 1ps
module cft_res_fifo import cft_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  input  logic      pop_i,
  output logic      valid_o,
  output res_item_t data_o,
  output logic      room_o
);

  res_item_t            mem_q [RES_DEPTH];
  res_item_t            head_q;
  logic [RES_PTR_W-1:0] wp_q, rp_q;
  logic [RES_CNT_W-1:0] cnt_q;
  logic [RES_PTR_W-1:0] wp_next;
  logic [RES_PTR_W-1:0] rp_d;

  assign wp_next = wp_q + RES_PTR_W'(1);
  assign rp_d    = rp_q + RES_PTR_W'(pop_i);
  assign valid_o = (cnt_q != '0);
  assign data_o  = head_q;
  // Room for the worst case of two results from one item.
  assign room_o  = (32'(cnt_q) <= RES_DEPTH - 2);

  always_ff @(posedge clk_i) begin
    if (push_i.push_cnt != 2'd0) mem_q[wp_q] <= push_i.r0;
    if (push_i.push_cnt == 2'd2) mem_q[wp_next] <= push_i.r1;
    // The head is read ahead; when the queue runs empty the first pushed
    // result goes straight to the head.
    if ((push_i.push_cnt != 2'd0) && (cnt_q == RES_CNT_W'(pop_i))) begin
      head_q <= push_i.r0;
    end else begin
      head_q <= mem_q[rp_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + RES_PTR_W'(push_i.push_cnt);
      rp_q  <= rp_d;
      cnt_q <= cnt_q + RES_CNT_W'(push_i.push_cnt) - RES_CNT_W'(pop_i);
    end
  end

endmodule

[design/cft_checker.sv]
`timescale 1ns / 1ps
`include "civ_frame_transceiver_unit_defines.svh"
module cft_checker import cft_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input res_item_t out_data_o
);

  logic stall;
  logic is_end;
  logic byte_clean;
  logic end_clean;

  assign stall      = out_valid_o && !out_ready_i;
  assign is_end     = (out_data_o.out_kind == KIND_END);
  assign byte_clean = (out_data_o.status == ST_OK) && (out_data_o.resp_count == 4'd0);
  assign end_clean  = (out_data_o.out_byte == 8'd0)
                      && (32'(out_data_o.resp_count) <= FRAME_DEPTH);

  `CFT_ASSERT_NEXT(a_out_hold, stall, out_valid_o && $stable(out_data_o), "held result changed")
  `CFT_ASSERT_IMPL(a_last_end, out_valid_o, out_data_o.last == is_end, "last flag mismatch")
  `CFT_ASSERT_IMPL(a_byte_clean, out_valid_o && !is_end, byte_clean, "byte result not clean")
  `CFT_ASSERT_IMPL(a_end_clean, out_valid_o && is_end, end_clean, "end result not clean")

endmodule

bind civ_frame_transceiver_unit cft_checker u_cft_checker (.*);

[verif/civ_frame_checker.sv]
`timescale 1ns / 1ps
module civ_frame_checker import cft_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  in_item_t   in_data_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  res_item_t  out_data_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output int         awaited_o,
  output int         mismatches_o,
  output logic       engine_idle_o
);

  logic [7:0]       cmd_bytes [FRAME_DEPTH];
  phase_e           eng_phase;
  logic [POS_W-1:0] tx_pos;
  logic [7:0]       echo_byte;
  logic [3:0]       attempt_no;
  logic [CNT_W-1:0] reply_len;
  logic [7:0]       target_addr;
  logic [7:0]       ctrl_addr;
  logic [3:0]       retry_limit;
  res_item_t        awaited_results [$];
  int               mismatch_cnt;

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) note_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
  endtask

  task automatic check_result(input res_item_t got);
    res_item_t want;
    if (awaited_results.size() == 0) begin
      note_mismatch($sformatf("result 0x%h arrived with nothing outstanding", got));
    end else begin
      want = awaited_results.pop_front();
      check_field("out_kind", 8'(got.out_kind), 8'(want.out_kind));
      check_field("out_byte", got.out_byte, want.out_byte);
      check_field("status", 8'(got.status), 8'(want.status));
      check_field("resp_count", 8'(got.resp_count), 8'(want.resp_count));
      check_field("last", 8'(got.last), 8'(want.last));
    end
  endtask

  task automatic push_result(input logic [1:0] kind, input logic [7:0] b, input logic [1:0] st,
                             input logic [3:0] cnt);
    res_item_t r;
    r.out_kind   = kind;
    r.out_byte   = b;
    r.status     = st;
    r.resp_count = cnt;
    r.last       = (kind == KIND_END);
    awaited_results.push_back(r);
  endtask

  task automatic end_frame(input logic [1:0] st, input logic [3:0] cnt);
    eng_phase = PH_IDLE;
    push_result(KIND_END, 8'h00, st, cnt);
  endtask

  task automatic send_byte(input logic [POS_W-1:0] pos, input logic [7:0] b);
    eng_phase = PH_ECHO;
    tx_pos    = pos;
    echo_byte = b;
    push_result(KIND_TX, b, ST_OK, 4'd0);
  endtask

  task automatic open_attempt();
    if (attempt_no >= retry_limit) end_frame(ST_NO_RESP, 4'd0);
    else send_byte(POS_W'(0), PRE_BYTE);
  endtask

  task automatic retry_frame();
    if (attempt_no != 4'hF) attempt_no++;
    open_attempt();
  endtask

  // Positions 0 to 3 are the header; from 4 on the store is sent until FI
  // has been echoed or the store runs out.
  task automatic echo_matched();
    int nxt;
    nxt = int'(tx_pos) - 3;
    if (tx_pos == POS_W'(0)) send_byte(POS_W'(1), PRE_BYTE);
    else if (tx_pos == POS_W'(1)) send_byte(POS_W'(2), target_addr);
    else if (tx_pos == POS_W'(2)) send_byte(POS_W'(3), ctrl_addr);
    else if (tx_pos == POS_W'(3)) send_byte(POS_W'(4), cmd_bytes[0]);
    else if (echo_byte != END_BYTE && nxt < FRAME_DEPTH) send_byte(tx_pos + 1'b1, cmd_bytes[nxt]);
    else if (cmd_bytes[0] <= 8'd1) end_frame(ST_OK, 4'd0);
    else eng_phase = PH_HUNT;
  endtask

  task automatic advance_frame_engine(input in_item_t it);
    logic [7:0] rx;
    rx = (it.req_type == REQ_TIMEOUT) ? END_BYTE : it.data_byte;
    if (it.req_type == REQ_LOAD) begin
      if (eng_phase == PH_IDLE && it.slot < FRAME_DEPTH) cmd_bytes[it.slot] = it.data_byte;
    end else if (it.req_type == REQ_START) begin
      if (eng_phase == PH_IDLE) begin
        attempt_no = 4'd0;
        open_attempt();
      end
    end else if (eng_phase != PH_IDLE) begin
      case (eng_phase)
        PH_ECHO: begin
          if (rx == echo_byte) echo_matched();
          else eng_phase = PH_DISCARD;
        end
        PH_DISCARD: begin
          if (rx == END_BYTE) retry_frame();
        end
        PH_HUNT: begin
          if (rx == END_BYTE || rx == PRE_BYTE) eng_phase = PH_SKIP_PRE;
        end
        PH_SKIP_PRE: begin
          if (rx != PRE_BYTE) begin
            if (rx != ctrl_addr) retry_frame();
            else eng_phase = PH_CHK_TARGET;
          end
        end
        PH_CHK_TARGET: begin
          if (rx != target_addr) begin
            retry_frame();
          end else begin
            eng_phase = PH_RX_BODY;
            reply_len = '0;
          end
        end
        PH_RX_BODY: begin
          if (rx == END_BYTE) begin
            end_frame(ST_OK, 4'(reply_len));
          end else begin
            push_result(KIND_BODY, rx, ST_OK, 4'd0);
            reply_len++;
            if (reply_len >= FRAME_DEPTH) end_frame(ST_OVERFLOW, 4'(reply_len));
          end
        end
        default: eng_phase = PH_IDLE;
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FRAME_DEPTH; i++) cmd_bytes[i] = 8'h00;
      eng_phase    = PH_IDLE;
      tx_pos       = '0;
      echo_byte    = 8'h00;
      attempt_no   = 4'd0;
      reply_len    = '0;
      target_addr  = TARGET_RST;
      ctrl_addr    = CTRL_RST;
      retry_limit  = RETRY_RST;
      mismatch_cnt = 0;
      awaited_results.delete();
    end else begin
      // Results are compared before this edge's input is predicted, as the
      // block cannot answer an item in the cycle it takes it.
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TARGET: target_addr = cfg_data_i;
          CFG_CTRL:   ctrl_addr = cfg_data_i;
          CFG_RETRY:  retry_limit = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) advance_frame_engine(in_data_i);
    end
    awaited_o     = awaited_results.size();
    mismatches_o  = mismatch_cnt;
    engine_idle_o = (eng_phase == PH_IDLE);
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
  import cft_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES   = 4;
  localparam int END_WAIT_LIMIT = 50000;
  localparam int PHASES         = 8;
  localparam logic [7:0] TARGET_SET [PHASES] =
    '{8'h00, 8'hFF, 8'hFE, 8'h5A, 8'h01, 8'h80, 8'hA4, 8'h3C};
  localparam logic [7:0] CTRL_SET [PHASES] =
    '{8'hE0, 8'h00, 8'hFD, 8'hE0, 8'hFF, 8'h7F, 8'hE1, 8'h10};
  localparam logic [3:0] RETRY_SET [PHASES] =
    '{4'd4, 4'd15, 4'd2, 4'd0, 4'd1, 4'd15, 4'd3, 4'd6};
  localparam int GAP_SET [4]   = '{0, 80, 0, 38};
  localparam int STALL_SET [4] = '{0, 0, 80, 38};

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  res_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0] cfg_index = CFG_TARGET;
  logic [7:0] cfg_data = 8'h00;

  int         awaited;
  int         mismatches;
  logic       engine_idle;
  int         gap_pct = 0;
  int         stall_pct = 0;
  int         counted_items = 0;
  logic [7:0] cur_target = TARGET_RST;
  logic [7:0] cur_ctrl = CTRL_RST;

  civ_frame_transceiver_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  civ_frame_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .awaited_o     (awaited),
    .mismatches_o  (mismatches),
    .engine_idle_o (engine_idle)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(negedge clk_i) out_ready <= ($urandom_range(99) >= stall_pct);

  initial begin
    #20_000_000;
    $display("FAIL civ_frame_transceiver_unit");
    $finish;
  end

  function automatic logic [7:0] pick_byte(input logic [7:0] not_a, input logic [7:0] not_b);
    logic [7:0] b;
    b = 8'($urandom);
    while (b == not_a || b == not_b) b = 8'($urandom);
    return b;
  endfunction

  task automatic send_item(input logic [1:0] rt, input logic [3:0] sl, input logic [7:0] db);
    // Only items the engine acts on count towards the stimulus volume.
    if ((engine_idle && (rt == REQ_LOAD || rt == REQ_START)) ||
        (!engine_idle && (rt == REQ_BUS || rt == REQ_TIMEOUT))) counted_items++;
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      in_data  = '{req_type: 2'($urandom), slot: 4'($urandom), data_byte: 8'($urandom)};
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data  = '{req_type: rt, slot: sl, data_byte: db};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic drive_to_idle();
    while (!engine_idle) send_item(REQ_TIMEOUT, 4'($urandom), 8'($urandom));
  endtask

  // One command transaction on a bus that echoes every byte, with collisions,
  // bad reply addresses, overflowing replies and ignored requests mixed in.
  task automatic run_exchange();
    logic [7:0] frame [FRAME_DEPTH + 4];
    logic [7:0] wrong;
    logic       no_fi;
    int         frame_len, hit, fault, body_len, tries, k;
    frame[0] = PRE_BYTE;
    frame[1] = PRE_BYTE;
    frame[2] = cur_target;
    frame[3] = cur_ctrl;
    for (k = 4; k < FRAME_DEPTH + 4; k++) frame[k] = pick_byte(END_BYTE, END_BYTE);
    no_fi = ($urandom_range(7) == 0);
    if (no_fi) frame_len = FRAME_DEPTH + 4;
    else if ($urandom_range(3) == 0) frame_len = 4 + $urandom_range(FRAME_DEPTH, 1);
    else frame_len = 4 + $urandom_range(4, 1);
    if (!no_fi) frame[frame_len - 1] = END_BYTE;
    if ((no_fi || frame_len > 5) && $urandom_range(3) == 0) frame[4] = 8'($urandom_range(1));

    for (k = 0; k < FRAME_DEPTH; k++) begin
      if (k < frame_len - 4) send_item(REQ_LOAD, 4'(k), frame[k + 4]);
      else if ($urandom_range(3) == 0) send_item(REQ_LOAD, 4'(k), 8'($urandom));
    end
    if ($urandom_range(7) == 0)
      send_item(REQ_LOAD, 4'($urandom_range(15, FRAME_DEPTH)), 8'($urandom));
    send_item(REQ_START, 4'($urandom), 8'($urandom));

    for (tries = 0; tries < 24 && !engine_idle; tries++) begin
      fault = $urandom_range(7);
      hit   = (fault == 0) ? $urandom_range(frame_len - 1) : frame_len;
      for (k = 0; k < hit; k++) begin
        if ($urandom_range(39) == 0)
          send_item(($urandom_range(1) == 0) ? REQ_LOAD : REQ_START, 4'($urandom), 8'($urandom));
        send_item((frame[k] == END_BYTE && $urandom_range(1) == 0) ? REQ_TIMEOUT : REQ_BUS,
                  4'($urandom), frame[k]);
      end
      if (fault == 0) begin
        // A collision that reads as FI must not end the discard by itself.
        wrong = (frame[hit] != END_BYTE && $urandom_range(1) == 0) ?
                END_BYTE : pick_byte(frame[hit], frame[hit]);
        send_item((wrong == END_BYTE && $urandom_range(1) == 0) ? REQ_TIMEOUT : REQ_BUS,
                  4'($urandom), wrong);
        repeat ($urandom_range(2)) send_item(REQ_BUS, 4'($urandom), pick_byte(END_BYTE, END_BYTE));
        send_item(($urandom_range(1) == 0) ? REQ_TIMEOUT : REQ_BUS, 4'($urandom), END_BYTE);
      end else if (frame[4] > 8'd1) begin
        if ($urandom_range(15) == 0) begin
          in_valid = 1'b0;
          while (awaited != 0) @(negedge clk_i);
        end
        repeat ($urandom_range(2))
          send_item(REQ_BUS, 4'($urandom), pick_byte(PRE_BYTE, END_BYTE));
        send_item(REQ_BUS, 4'($urandom), ($urandom_range(7) == 0) ? END_BYTE : PRE_BYTE);
        repeat ($urandom_range(2)) send_item(REQ_BUS, 4'($urandom), PRE_BYTE);
        if (fault == 1 && $urandom_range(1) == 0) begin
          send_item(REQ_BUS, 4'($urandom), pick_byte(cur_ctrl, PRE_BYTE));
          continue;
        end
        send_item(REQ_BUS, 4'($urandom), cur_ctrl);
        if (fault == 1) begin
          send_item(REQ_BUS, 4'($urandom), pick_byte(cur_target, cur_target));
          continue;
        end
        send_item(REQ_BUS, 4'($urandom), cur_target);
        body_len = ($urandom_range(7) == 0) ?
                   $urandom_range(FRAME_DEPTH + 1, FRAME_DEPTH - 1) : $urandom_range(5);
        for (k = 0; k < body_len; k++)
          send_item(REQ_BUS, 4'($urandom), pick_byte(END_BYTE, END_BYTE));
        if (body_len < FRAME_DEPTH)
          send_item(($urandom_range(1) == 0) ? REQ_TIMEOUT : REQ_BUS, 4'($urandom), END_BYTE);
      end
    end
    drive_to_idle();
  endtask

  initial begin
    int ph, quota_end, k;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: ignored requests while idle, a full store load with a
    // short command, and a start while busy.
    send_item(REQ_TIMEOUT, 4'h0, 8'h00);
    send_item(REQ_BUS, 4'hF, PRE_BYTE);
    send_item(REQ_LOAD, 4'd0, 8'h00);
    send_item(REQ_LOAD, 4'd1, END_BYTE);
    for (k = 2; k < FRAME_DEPTH; k++) send_item(REQ_LOAD, 4'(k), (k % 2 == 0) ? 8'hFF : 8'h00);
    send_item(REQ_LOAD, 4'hF, 8'hFF);
    send_item(REQ_START, 4'hF, 8'hFF);
    send_item(REQ_BUS, 4'h0, PRE_BYTE);
    send_item(REQ_START, 4'h0, 8'h00);
    send_item(REQ_BUS, 4'h0, PRE_BYTE);
    send_item(REQ_BUS, 4'h0, TARGET_RST);
    send_item(REQ_BUS, 4'h0, CTRL_RST);
    send_item(REQ_BUS, 4'h0, 8'h00);
    send_item(REQ_BUS, 4'h0, END_BYTE);
    drive_to_idle();

    for (ph = 0; ph < PHASES; ph++) begin
      in_valid = 1'b0;
      while (awaited != 0) @(negedge clk_i);
      repeat (DRAIN_CYCLES) @(negedge clk_i);
      write_register(CFG_TARGET, TARGET_SET[ph]);
      write_register(CFG_CTRL, CTRL_SET[ph]);
      write_register(CFG_RETRY, {4'($urandom), RETRY_SET[ph]});
      if (ph == 0) write_register(CFG_UNUSED, 8'($urandom));
      cur_target = TARGET_SET[ph];
      cur_ctrl   = CTRL_SET[ph];
      gap_pct    = GAP_SET[ph % 4];
      stall_pct  = STALL_SET[ph % 4];
      quota_end  = counted_items + ((RETRY_SET[ph] == 4'd0) ? 30 : 280);
      while (counted_items < quota_end) begin
        if ($urandom_range(9) == 0) begin
          repeat (16) send_item(2'($urandom), 4'($urandom), 8'($urandom));
          drive_to_idle();
        end else begin
          run_exchange();
        end
      end
    end

    in_valid = 1'b0;
    for (k = 0; k < END_WAIT_LIMIT && awaited != 0; k++) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && awaited == 0) begin
      $display("PASS civ_frame_transceiver_unit");
    end else begin
      $display("FAIL civ_frame_transceiver_unit");
    end
    $finish;
  end

endmodule
